>>> design/rosob_pkg.sv
// ----------------------------------------------------------------------------
// rosob_pkg
// Shared types, register codes, reset values and the blend arithmetic of the
// rectangle overlay blender.
// ----------------------------------------------------------------------------
`default_nettype none

package rosob_pkg;

	// Pixel coordinate as it arrives, and a widened form for edge sums.
	typedef logic signed [15:0] coord_t;
	typedef logic signed [17:0] wcoord_t;
	typedef logic [7:0]         chan_t;
	typedef logic [31:0]        rgba_t;

	// Channel 0 is red, 1 is green, 2 is blue.
	localparam int NUM_CHANS = 3;
	typedef chan_t [NUM_CHANS-1:0] rgb_t;

	// Blend operations in the order they are applied.
	localparam int NUM_OPS      = 7;
	localparam int OP_TOP       = 0;
	localparam int OP_BOTTOM    = 1;
	localparam int OP_LEFT      = 2;
	localparam int OP_RIGHT     = 3;
	localparam int OP_SH_RIGHT  = 4;
	localparam int OP_SH_BOTTOM = 5;
	localparam int OP_FILL      = 6;
	typedef logic [NUM_OPS-1:0] opmask_t;

	// One classified pixel: which blends apply and the background color.
	typedef struct packed {
		opmask_t ops;
		rgb_t    rgb;
	} item_t;

	// Configuration register file contents.
	typedef struct packed {
		coord_t left_edge;
		coord_t top_edge;
		coord_t right_edge;
		coord_t bottom_edge;
		chan_t  shadow_width;
		rgba_t  border_rgba;
		rgba_t  fill_rgba;
		rgba_t  shadow_rgba;
	} cfg_t;

	// Register indexes on the configuration port.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_EDGE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_EDGE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_EDGE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_EDGE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHADOW_WIDTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BORDER_RGBA  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_RGBA    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SHADOW_RGBA  = 3'd7;

	// Reset values of the registers.
	localparam coord_t RST_LEFT_EDGE    = 16'sd0;
	localparam coord_t RST_TOP_EDGE     = 16'sd0;
	localparam coord_t RST_RIGHT_EDGE   = -16'sd1;
	localparam coord_t RST_BOTTOM_EDGE  = -16'sd1;
	localparam chan_t  RST_SHADOW_WIDTH = 8'd0;
	localparam rgba_t  RST_BORDER_RGBA  = 32'h0000_00ff;
	localparam rgba_t  RST_FILL_RGBA    = 32'hffff_ff00;
	localparam rgba_t  RST_SHADOW_RGBA  = 32'h0000_00ff;

	// Sign extension of a coordinate to the widened form.
	function automatic wcoord_t widen(input coord_t v);
		return {{2{v[15]}}, v};
	endfunction

	// Color byte of one channel; red sits in the top byte, alpha in the low.
	function automatic chan_t rgba_chan(input rgba_t c, input int ch);
		return c[31-8*ch -: 8];
	endfunction

	// ((255-a)*bg + c*a + 127) / 255. The sum stays below 2^16, where
	// (v + 1 + (v >> 8)) >> 8 equals v / 255 exactly.
	function automatic chan_t blend_chan(input chan_t bg, input chan_t c, input chan_t a);
		logic [15:0] p_bg;
		logic [15:0] p_c;
		logic [16:0] v;
		logic [16:0] t;
		p_bg = {8'd0, ~a} * {8'd0, bg};
		p_c  = {8'd0, c} * {8'd0, a};
		v    = {1'b0, p_bg} + {1'b0, p_c} + 17'd127;
		t    = v + 17'd1 + {8'd0, v[16:8]};
		return t[15:8];
	endfunction

endpackage

`default_nettype wire

>>> design/rect_outline_shadow_overlay_blend.sv
// ----------------------------------------------------------------------------
// rect_outline_shadow_overlay_blend
// Blends a rectangle outline, drop shadow and interior fill onto a stream of
// background pixels, one pixel word per clock unless the input is stalled.
// ----------------------------------------------------------------------------
//  Channel | Handshake               | Payload
//  input   | in_valid / in_stall     | pixel_x, pixel_y, in_red, in_green, in_blue
//  output  | out_valid / out_stall   | out_red, out_green, out_blue
//  config  | cfg_we                  | cfg_index, cfg_data
//
// One word is accepted per clock while in_stall is low. A word's accepting
// edge loads the input stage; with the queue empty, one queue slot and eight
// blend pipeline stages follow. The blend pipeline halts as a whole while the
// output word is stalled; the queue absorbs QueueDepth words, the input stage
// one more, before in_stall rises. Reset clears all valid flags and loads the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_outline_shadow_overlay_blend #(
	parameter int QueueDepth = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [rosob_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire rosob_pkg::coord_t             pixel_x,
	input  wire rosob_pkg::coord_t             pixel_y,
	input  wire rosob_pkg::chan_t              in_red,
	input  wire rosob_pkg::chan_t              in_green,
	input  wire rosob_pkg::chan_t              in_blue,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output rosob_pkg::chan_t                   out_red,
	output rosob_pkg::chan_t                   out_green,
	output rosob_pkg::chan_t                   out_blue
);
	import rosob_pkg::*;

	cfg_t  cfg_q;
	logic  push, full, pop, empty;
	item_t push_item, head;
	rgb_t  out_rgb;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_edge    <= RST_LEFT_EDGE;
			cfg_q.top_edge     <= RST_TOP_EDGE;
			cfg_q.right_edge   <= RST_RIGHT_EDGE;
			cfg_q.bottom_edge  <= RST_BOTTOM_EDGE;
			cfg_q.shadow_width <= RST_SHADOW_WIDTH;
			cfg_q.border_rgba  <= RST_BORDER_RGBA;
			cfg_q.fill_rgba    <= RST_FILL_RGBA;
			cfg_q.shadow_rgba  <= RST_SHADOW_RGBA;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT_EDGE:    cfg_q.left_edge    <= cfg_data[15:0];
				REG_TOP_EDGE:     cfg_q.top_edge     <= cfg_data[15:0];
				REG_RIGHT_EDGE:   cfg_q.right_edge   <= cfg_data[15:0];
				REG_BOTTOM_EDGE:  cfg_q.bottom_edge  <= cfg_data[15:0];
				REG_SHADOW_WIDTH: cfg_q.shadow_width <= cfg_data[7:0];
				REG_BORDER_RGBA:  cfg_q.border_rgba  <= cfg_data;
				REG_FILL_RGBA:    cfg_q.fill_rgba    <= cfg_data;
				REG_SHADOW_RGBA:  cfg_q.shadow_rgba  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rosob_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	rosob_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	rosob_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_rgb   (out_rgb)
	);

	assign out_red   = out_rgb[0];
	assign out_green = out_rgb[1];
	assign out_blue  = out_rgb[2];

endmodule

`default_nettype wire

>>> design/rosob_front.sv
// ----------------------------------------------------------------------------
// rosob_front
// Input stage: registers one pixel word and classifies it against the
// rectangle edges, shadow bands and interior, then hands it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rosob_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rosob_pkg::cfg_t   cfg,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire rosob_pkg::coord_t pixel_x,
	input  wire rosob_pkg::coord_t pixel_y,
	input  wire rosob_pkg::chan_t  in_red,
	input  wire rosob_pkg::chan_t  in_green,
	input  wire rosob_pkg::chan_t  in_blue,
	output logic                   push,
	output rosob_pkg::item_t       push_item,
	input  wire logic              full
);
	import rosob_pkg::*;

	logic    valid_s1;
	coord_t  x_s1;
	coord_t  y_s1;
	rgb_t    rgb_s1;
	logic    load;
	wcoord_t x, y, x0, y0, x1, y1, s;
	logic    in_cull, rows_mid, cols_span;
	opmask_t ops;

	// The stage takes a new word whenever its current one can leave.
	assign in_stall = valid_s1 && full;
	assign load     = in_valid && !in_stall;
	assign push     = valid_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_s1   <= pixel_x;
			y_s1   <= pixel_y;
			rgb_s1 <= {in_blue, in_green, in_red};
		end
	end

	// Region tests on widened coordinates so that edge sums cannot wrap.
	always_comb begin
		x  = widen(x_s1);
		y  = widen(y_s1);
		x0 = widen(cfg.left_edge);
		y0 = widen(cfg.top_edge);
		x1 = widen(cfg.right_edge);
		y1 = widen(cfg.bottom_edge);
		s  = {10'd0, cfg.shadow_width};

		in_cull   = (x0 <= x) && (y0 <= y) && (x1 + s >= x) && (y1 + s >= y);
		rows_mid  = (y >= y0 + 18'sd1) && (y <= y1 - 18'sd1);
		cols_span = (x >= x0) && (x <= x1);

		ops               = '0;
		ops[OP_TOP]       = cols_span && (y == y0);
		ops[OP_BOTTOM]    = cols_span && (y == y1);
		ops[OP_LEFT]      = (x == x0) && rows_mid;
		ops[OP_RIGHT]     = (x == x1) && rows_mid;
		ops[OP_SH_RIGHT]  = (s != '0) && (x >= x1 + 18'sd1) && (x <= x1 + s)
			&& (y >= y0 + s) && (y <= y1 + s);
		ops[OP_SH_BOTTOM] = (s != '0) && (x >= x0 + s) && (x <= x1)
			&& (y >= y1 + 18'sd1) && (y <= y1 + s);
		ops[OP_FILL]      = (x >= x0 + 18'sd1) && (x <= x1 - 18'sd1) && rows_mid;

		push_item.ops = in_cull ? ops : '0;
		push_item.rgb = rgb_s1;
	end

endmodule

`default_nettype wire

>>> design/rosob_queue.sv
// ----------------------------------------------------------------------------
// rosob_queue
// Small register queue of classified pixel words between the front and the
// blend pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rosob_queue #(
	parameter int Depth = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire rosob_pkg::item_t push_item,
	output logic                  full,
	input  wire logic             pop,
	output rosob_pkg::item_t      head,
	output logic                  empty
);
	import rosob_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	item_t           entry_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == FullCnt);
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	// Pointers wrap at the last entry; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

>>> design/rosob_back.sv
// ----------------------------------------------------------------------------
// rosob_back
// Blend pipeline: entry stage and one stage per blend operation, each applying
// its color only when the pixel word calls for it. The last stage is the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module rosob_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rosob_pkg::cfg_t  cfg,
	output logic                  pop,
	input  wire rosob_pkg::item_t head,
	input  wire logic             empty,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output rosob_pkg::rgb_t       out_rgb
);
	import rosob_pkg::*;

	localparam int LAST = NUM_OPS;

	logic  stg_valid_s [LAST+1];
	item_t stg_item_s  [LAST+1];
	item_t stg_next    [LAST];
	logic  adv;

	// Color used by each blend operation.
	function automatic rgba_t op_color(input int k, input cfg_t c);
		if (k <= OP_RIGHT) begin
			return c.border_rgba;
		end else if (k <= OP_SH_BOTTOM) begin
			return c.shadow_rgba;
		end
		return c.fill_rgba;
	endfunction

	// The whole pipeline moves unless a finished word is held at the output.
	assign adv       = !(stg_valid_s[LAST] && out_stall);
	assign pop       = adv && !empty;
	assign out_valid = stg_valid_s[LAST];
	assign out_rgb   = stg_item_s[LAST].rgb;

	// Blend logic between stage k and stage k+1.
	always_comb begin
		rgba_t col;
		for (int k = 0; k < NUM_OPS; k++) begin
			col         = op_color(k, cfg);
			stg_next[k] = stg_item_s[k];
			for (int ch = 0; ch < NUM_CHANS; ch++) begin
				if (stg_item_s[k].ops[k]) begin
					stg_next[k].rgb[ch] = blend_chan(stg_item_s[k].rgb[ch],
						rgba_chan(col, ch), col[7:0]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LAST; k++) begin
				stg_valid_s[k] <= 1'b0;
			end
		end else if (adv) begin
			stg_valid_s[0] <= !empty;
			for (int k = 0; k < LAST; k++) begin
				stg_valid_s[k+1] <= stg_valid_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stg_item_s[0] <= head;
			for (int k = 0; k < LAST; k++) begin
				stg_item_s[k+1] <= stg_next[k];
			end
		end
	end

endmodule

`default_nettype wire

>>> design/rosob_checker.sv
// ----------------------------------------------------------------------------
// rosob_checker
// Port-level checks of the rectangle overlay blender, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rosob_checker #(
	parameter int QueueDepth = 4
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_red,
	input wire logic [7:0] out_green,
	input wire logic [7:0] out_blue
);

	// Words in flight: input stage, queue entries and blend stages.
	localparam int MaxInFlight = QueueDepth + 9;

	logic [15:0] inflight_q;
	logic        in_acc, out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 16'd1;
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - 16'd1;
		end
	end

	// No output word without an accepted input word behind it.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (inflight_q != 16'd0))
		else $error("output word without a pending input word");

	// The block never holds more words than its storage.
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 16'(MaxInFlight))
		else $error("more words in flight than storage allows");

	// The input side stalls only after the output has been held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> $past(out_valid && out_stall))
		else $error("input stalled without output back-pressure");

	// A held output word keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_red)
			&& $stable(out_green) && $stable(out_blue)))
		else $error("stalled output word changed");

endmodule

bind rect_outline_shadow_overlay_blend rosob_checker #(
	.QueueDepth (QueueDepth)
) u_rosob_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_red   (out_red),
	.out_green (out_green),
	.out_blue  (out_blue)
);

`default_nettype wire
